// ----- src/stq_pkg.sv -----
// Shared types and constants for the sorted timer deadline queue.
// No dependencies; every other file imports this package.
package stq_pkg;

  localparam int QueueDepth  = 16;
  localparam int CountW      = $clog2(QueueDepth + 1);
  localparam int IdxW        = $clog2(QueueDepth);
  localparam int EntryCountW = 5;
  localparam int DeadlineW   = 64;
  localparam int TimeoutW    = 32;
  localparam int FreqW       = 32;
  localparam int HandlerW    = 8;
  localparam int ArgW        = 16;

  localparam logic [FreqW-1:0] ClockFreqReset = FreqW'(19200000);

  localparam logic OpAdd = 1'b0;
  localparam logic OpPop = 1'b1;

  // One held timer
  typedef struct packed {
    logic [DeadlineW-1:0] deadline;
    logic [HandlerW-1:0]  handler;
    logic [ArgW-1:0]      arg;
  } entry_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_cmd_t;

endpackage

// ----- src/stq_if.sv -----
// Handshake interfaces for the timer queue: request, response and config write.
// Depends on stq_pkg.
interface stq_req_if;
  import stq_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [DeadlineW-1:0] now;
  logic [TimeoutW-1:0] timeout;
  logic                by_tick;
  logic [HandlerW-1:0] handler_id;
  logic [ArgW-1:0]     arg_handle;
  modport source (output valid, op, now, timeout, by_tick, handler_id, arg_handle,
                  input ready);
  modport sink (input valid, op, now, timeout, by_tick, handler_id, arg_handle,
                output ready);
endinterface

interface stq_rsp_if;
  import stq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [DeadlineW-1:0]   compare_value;
  logic                   compare_valid;
  logic                   popped_valid;
  logic [HandlerW-1:0]    popped_handler;
  logic [ArgW-1:0]        popped_arg;
  logic                   add_dropped;
  logic [EntryCountW-1:0] entry_count;
  modport source (output valid, compare_value, compare_valid, popped_valid,
                  popped_handler, popped_arg, add_dropped, entry_count,
                  input ready);
  modport sink (input valid, compare_value, compare_valid, popped_valid,
                popped_handler, popped_arg, add_dropped, entry_count,
                output ready);
endinterface

interface stq_cfg_if;
  import stq_pkg::*;
  logic             valid;
  logic             ready;
  logic [FreqW-1:0] clock_freq;
  modport source (output valid, clock_freq, input ready);
  modport sink (input valid, clock_freq, output ready);
endinterface

// ----- src/stq_cell.sv -----
// One slot of the sorted queue: holds an entry, compares it with the new
// deadline and shifts with its neighbors. Depends on stq_pkg.
module stq_cell (
  input  logic              clk_i,
  input  stq_pkg::cell_cmd_t cmd_i,
  input  logic              valid_i,
  input  logic              prev_keep_i,
  input  stq_pkg::entry_t   prev_ent_i,
  input  stq_pkg::entry_t   next_ent_i,
  output logic              keep_o,
  output stq_pkg::entry_t   ent_o
);
  import stq_pkg::*;

  entry_t ent_q, ent_d;

  // Keep the entry when it is held and not later than the new deadline
  assign keep_o = valid_i && (ent_q.deadline <= cmd_i.ent.deadline);

  // Hold, take the new entry, or shift from a neighbor
  always_comb begin
    ent_d = ent_q;
    if (cmd_i.pop) begin
      ent_d = next_ent_i;
    end else if (cmd_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        ent_d = cmd_i.ent;
      end else begin
        ent_d = prev_ent_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- src/sorted_timer_deadline_queue.sv -----
// Top level of the sorted timer deadline queue: controller, deadline math and
// a row of stq_cell slots. Depends on stq_pkg, stq_if and stq_cell.
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        op, now, timeout, by_tick, handler_id, arg_handle
//  rsp      out  valid/ready        compare_value .. entry_count
//  cfg      in   valid/ready(=1)    clock_freq
//
// An add passes through S_MUL for the 32x32 multiply, S_ADD for the 64-bit
// deadline add, S_APPLY for the compare and shift across the cell row and
// S_REPORT to load the response register; a pop skips S_MUL and S_ADD. The
// input reopens as the response is loaded, so a new request is taken only once
// the last one is reported. Reset empties the queue and loads the default clock
// frequency. A stalled response holds back the next report and the input.
module sorted_timer_deadline_queue (
  input logic     clk_i,
  input logic     rst_ni,
  stq_req_if.sink   req,
  stq_rsp_if.source rsp,
  stq_cfg_if.sink   cfg
);
  import stq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_ADD    = 5'b00100,
    S_APPLY  = 5'b01000,
    S_REPORT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [FreqW-1:0]     clock_freq_q;
  logic                 op_q;
  logic [DeadlineW-1:0] now_q;
  logic [TimeoutW-1:0]  timeout_q;
  logic                 by_tick_q;
  logic [DeadlineW-1:0] delta_q;
  entry_t               new_q;
  logic [CountW-1:0]    count_q;

  logic                 popped_valid_q;
  logic [HandlerW-1:0]  popped_handler_q;
  logic [ArgW-1:0]      popped_arg_q;
  logic                 add_dropped_q;

  logic                   rsp_valid_q;
  logic [DeadlineW-1:0]   rsp_compare_value_q;
  logic                   rsp_compare_valid_q;
  logic                   rsp_popped_valid_q;
  logic [HandlerW-1:0]    rsp_popped_handler_q;
  logic [ArgW-1:0]        rsp_popped_arg_q;
  logic                   rsp_add_dropped_q;
  logic [EntryCountW-1:0] rsp_entry_count_q;

  logic                          req_fire;
  logic                          do_pop;
  logic                          do_ins;
  cell_cmd_t                     cmd;
  logic [QueueDepth-1:0]         vld;
  logic [QueueDepth-1:0]         keep;
  entry_t                        ent [QueueDepth];
  logic [CountW+EntryCountW-1:0] count_wide;

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_freq_q <= ClockFreqReset;
    end else if (cfg.valid && cfg.ready) begin
      clock_freq_q <= cfg.clock_freq;
    end
  end

  // Sequence one request through the stages
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = (req.op == OpPop) ? S_APPLY : S_MUL;
        end
      end
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_APPLY;
      S_APPLY: state_d = S_REPORT;
      S_REPORT: begin
        if (!rsp_valid_q || rsp.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request, then multiply and add the deadline
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q        <= req.op;
      now_q       <= req.now;
      timeout_q   <= req.timeout;
      by_tick_q   <= req.by_tick;
      new_q.handler <= req.handler_id;
      new_q.arg     <= req.arg_handle;
    end
    // Widen both operands so the full 64-bit product is kept
    if (state_q == S_MUL) begin
      delta_q <= by_tick_q ? {{(DeadlineW-TimeoutW){1'b0}}, timeout_q}
                           : DeadlineW'(timeout_q) * DeadlineW'(clock_freq_q);
    end
    if (state_q == S_ADD) begin
      new_q.deadline <= now_q + delta_q;
    end
  end

  // Apply the request to the cell row
  assign do_pop = (state_q == S_APPLY) && (op_q == OpPop) && (count_q != '0);
  assign do_ins = (state_q == S_APPLY) && (op_q == OpAdd) &&
                  (count_q != CountW'(QueueDepth));

  assign cmd.ins = do_ins;
  assign cmd.pop = do_pop;
  assign cmd.ent = new_q;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    assign vld[i] = (CountW'(i) < count_q);
    stq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (vld[i]),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
      .prev_ent_i  (ent[(i == 0) ? 0 : i-1]),
      .next_ent_i  (ent[(i == QueueDepth-1) ? i : i+1]),
      .keep_o      (keep[i]),
      .ent_o       (ent[i])
    );
  end

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_pop) begin
      count_q <= count_q - CountW'(1);
    end else if (do_ins) begin
      count_q <= count_q + CountW'(1);
    end
  end

  // Record what the request did
  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY) begin
      popped_valid_q   <= do_pop;
      popped_handler_q <= do_pop ? ent[0].handler : '0;
      popped_arg_q     <= do_pop ? ent[0].arg : '0;
      add_dropped_q    <= (op_q == OpAdd) && !do_ins;
    end
  end

  assign count_wide = {{EntryCountW{1'b0}}, count_q};

  // Load the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((state_q == S_REPORT) && (!rsp_valid_q || rsp.ready)) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_REPORT) && (!rsp_valid_q || rsp.ready)) begin
      rsp_compare_valid_q  <= (count_q != '0);
      rsp_compare_value_q  <= (count_q != '0) ? ent[0].deadline : '0;
      rsp_popped_valid_q   <= popped_valid_q;
      rsp_popped_handler_q <= popped_handler_q;
      rsp_popped_arg_q     <= popped_arg_q;
      rsp_add_dropped_q    <= add_dropped_q;
      rsp_entry_count_q    <= count_wide[EntryCountW-1:0];
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.compare_value  = rsp_compare_value_q;
  assign rsp.compare_valid  = rsp_compare_valid_q;
  assign rsp.popped_valid   = rsp_popped_valid_q;
  assign rsp.popped_handler = rsp_popped_handler_q;
  assign rsp.popped_arg     = rsp_popped_arg_q;
  assign rsp.add_dropped    = rsp_add_dropped_q;
  assign rsp.entry_count    = rsp_entry_count_q;

  // Occupancy never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("queue occupancy above depth");

  // Occupancy moves only while a request is applied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> (count_q == $past(count_q)))
    else $error("occupancy changed outside apply");

  // A reported pop never also reports a dropped add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_popped_valid_q && rsp_add_dropped_q))
    else $error("pop and drop reported together");

endmodule

// ----- tb/tb_sorted_timer_deadline_queue.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timer_deadline_queue: a queue-fed driver, a
// checking monitor and a behavioral deadline queue that predicts every response.
// Depends on stq_pkg, stq_if and the RTL of the block.
module tb_sorted_timer_deadline_queue;
  import stq_pkg::*;

  localparam int MaxCycles  = 200000;
  localparam int HoldCycles = 300;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic                 op;
    logic [DeadlineW-1:0] now;
    logic [TimeoutW-1:0]  timeout;
    logic                 by_tick;
    logic [HandlerW-1:0]  handler;
    logic [ArgW-1:0]      arg;
  } timer_req_t;

  typedef struct packed {
    logic [DeadlineW-1:0]   compare_value;
    logic                   compare_valid;
    logic                   popped_valid;
    logic [HandlerW-1:0]    popped_handler;
    logic [ArgW-1:0]        popped_arg;
    logic                   add_dropped;
    logic [EntryCountW-1:0] entry_count;
  } timer_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  stq_req_if req_if ();
  stq_rsp_if rsp_if ();
  stq_cfg_if cfg_if ();

  sorted_timer_deadline_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // Stimulus backlog and expected head reports
  timer_req_t req_backlog[$];
  timer_rsp_t expected_reports[$];
  timer_req_t in_flight;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_on = 1'b0;

  // Behavioral copy of the deadline queue
  logic [DeadlineW-1:0] held_deadline [QueueDepth];
  logic [HandlerW-1:0]  held_handler [QueueDepth];
  logic [ArgW-1:0]      held_arg [QueueDepth];
  int                   held_count = 0;
  logic [FreqW-1:0]     model_freq = ClockFreqReset;

  // Reuse of the last deadline inputs produces equal-deadline ties
  logic [DeadlineW-1:0] last_now = '0;
  logic [TimeoutW-1:0]  last_timeout = '0;
  logic                 last_by_tick = 1'b1;

  int accepted = 0;
  int checked = 0;
  int failures = 0;
  int dropped_adds = 0;
  int empty_pops = 0;
  int full_seen = 0;
  int freq_writes = 0;
  int cycle_count = 0;

  // Apply one request to the queue copy and return the report it causes
  function automatic timer_rsp_t apply_timer_req(timer_req_t r);
    timer_rsp_t rsp;
    logic [DeadlineW-1:0] due;
    int pos;
    rsp = '0;
    if (r.op == OpPop) begin
      if (held_count > 0) begin
        rsp.popped_valid = 1'b1;
        rsp.popped_handler = held_handler[0];
        rsp.popped_arg = held_arg[0];
        for (int i = 1; i < held_count; i++) begin
          held_deadline[i-1] = held_deadline[i];
          held_handler[i-1] = held_handler[i];
          held_arg[i-1] = held_arg[i];
        end
        held_count--;
      end else begin
        empty_pops++;
      end
    end else if (held_count >= QueueDepth) begin
      rsp.add_dropped = 1'b1;
      dropped_adds++;
    end else begin
      if (r.by_tick) due = r.now + DeadlineW'(r.timeout);
      else due = r.now + DeadlineW'(r.timeout) * DeadlineW'(model_freq);
      // Insert after every entry that is not later, so ties keep arrival order
      pos = 0;
      while (pos < held_count && held_deadline[pos] <= due) pos++;
      for (int i = held_count; i > pos; i--) begin
        held_deadline[i] = held_deadline[i-1];
        held_handler[i] = held_handler[i-1];
        held_arg[i] = held_arg[i-1];
      end
      held_deadline[pos] = due;
      held_handler[pos] = r.handler;
      held_arg[pos] = r.arg;
      held_count++;
      if (held_count == QueueDepth) full_seen++;
    end
    if (held_count > 0) begin
      rsp.compare_value = held_deadline[0];
      rsp.compare_valid = 1'b1;
    end
    rsp.entry_count = EntryCountW'(held_count);
    return rsp;
  endfunction

  // Build a request with random content, sometimes repeating the last deadline
  function automatic timer_req_t make_timer_req(logic op);
    timer_req_t r;
    r.op = op;
    if ($urandom_range(5) == 0) begin
      r.now = last_now;
      r.timeout = last_timeout;
      r.by_tick = last_by_tick;
    end else begin
      case ($urandom_range(3))
        0: r.now = DeadlineW'($urandom_range(1000));
        1: r.now = ~DeadlineW'($urandom_range(1000));
        default: r.now = {$urandom, $urandom};
      endcase
      case ($urandom_range(3))
        0: r.timeout = '0;
        1: r.timeout = '1;
        2: r.timeout = TimeoutW'($urandom_range(100));
        default: r.timeout = $urandom;
      endcase
      r.by_tick = 1'($urandom_range(1));
    end
    r.handler = HandlerW'($urandom_range(255));
    r.arg = ArgW'($urandom_range(65535));
    last_now = r.now;
    last_timeout = r.timeout;
    last_by_tick = r.by_tick;
    return r;
  endfunction

  task automatic push_add(logic [DeadlineW-1:0] n, logic [TimeoutW-1:0] t, logic bt,
                          logic [HandlerW-1:0] h, logic [ArgW-1:0] a);
    timer_req_t r;
    r = '{op: OpAdd, now: n, timeout: t, by_tick: bt, handler: h, arg: a};
    req_backlog.push_back(r);
  endtask

  // Random requests in bursts that lean toward adds, toward pops or to neither side
  task automatic queue_random_items(int n);
    int add_pct;
    add_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(3))
          0: add_pct = 25;
          1: add_pct = 50;
          2: add_pct = 75;
          default: add_pct = 95;
        endcase
      end
      if ($urandom_range(99) < add_pct) req_backlog.push_back(make_timer_req(OpAdd));
      else req_backlog.push_back(make_timer_req(OpPop));
    end
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_if.valid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  // Write the clock frequency while the queue is idle
  task automatic write_clock_freq(logic [FreqW-1:0] f);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.clock_freq <= f;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    model_freq = f;
    freq_writes++;
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_items(n);
    wait_drained();
  endtask

  // Driver: offer backlog requests, predict each one as it is accepted
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.op <= OpAdd;
      req_if.now <= '0;
      req_if.timeout <= '0;
      req_if.by_tick <= 1'b0;
      req_if.handler_id <= '0;
      req_if.arg_handle <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_reports.push_back(apply_timer_req(in_flight));
        accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = req_backlog.pop_front();
          req_if.valid <= 1'b1;
          req_if.op <= in_flight.op;
          req_if.now <= in_flight.now;
          req_if.timeout <= in_flight.timeout;
          req_if.by_tick <= in_flight.by_tick;
          req_if.handler_id <= in_flight.handler;
          req_if.arg_handle <= in_flight.arg;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each response with the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    timer_rsp_t got;
    timer_rsp_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{compare_value: rsp_if.compare_value, compare_valid: rsp_if.compare_valid,
                popped_valid: rsp_if.popped_valid, popped_handler: rsp_if.popped_handler,
                popped_arg: rsp_if.popped_arg, add_dropped: rsp_if.add_dropped,
                entry_count: rsp_if.entry_count};
        if (expected_reports.size() == 0) begin
          failures++;
          if (failures <= MaxReports)
            $display("%0t: response with no request outstanding: cmp=%h", $realtime,
                     got.compare_value);
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (got.compare_value !== want.compare_value ||
              got.compare_valid !== want.compare_valid ||
              got.popped_valid !== want.popped_valid ||
              got.popped_handler !== want.popped_handler ||
              got.popped_arg !== want.popped_arg ||
              got.add_dropped !== want.add_dropped ||
              got.entry_count !== want.entry_count) begin
            failures++;
            if (failures <= MaxReports) begin
              $display("%0t: mismatch on response %0d", $realtime, checked);
              $display("  want cmp=%h/%b pop=%b h=%h a=%h drop=%b cnt=%0d",
                       want.compare_value, want.compare_valid, want.popped_valid,
                       want.popped_handler, want.popped_arg, want.add_dropped,
                       want.entry_count);
              $display("  got  cmp=%h/%b pop=%b h=%h a=%h drop=%b cnt=%0d",
                       got.compare_value, got.compare_valid, got.popped_valid,
                       got.popped_handler, got.popped_arg, got.add_dropped,
                       got.entry_count);
            end
          end
        end
      end
      rsp_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold off the response side for a long stretch so the block backs up
  initial begin : rsp_hold
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MaxCycles) begin
      $display("timeout after %0d cycles, %0d responses outstanding", MaxCycles,
               expected_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OpAdd;
    req_if.now = '0;
    req_if.timeout = '0;
    req_if.by_tick = 1'b0;
    req_if.handler_id = '0;
    req_if.arg_handle = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.clock_freq = ClockFreqReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pop, overflow and tie adds, fill to full, drop, pops
    req_backlog.push_back(make_timer_req(OpPop));
    push_add('0, '0, 1'b1, 8'h00, 16'h0000);
    push_add('1, '1, 1'b1, 8'hFF, 16'hFFFF);
    push_add('1, 32'd1, 1'b1, 8'h10, 16'h0010);
    push_add('0, '1, 1'b0, 8'h11, 16'h0011);
    push_add(64'hFFFF_FFFF_0000_0000, '1, 1'b0, 8'h12, 16'h0012);
    push_add(64'd100, '0, 1'b1, 8'h01, 16'h0001);
    push_add(64'd50, 32'd50, 1'b1, 8'h02, 16'h0002);
    push_add('0, 32'd1, 1'b0, 8'h03, 16'h0003);
    push_add('1, '0, 1'b1, 8'h04, 16'h0004);
    for (int k = 0; k < 7; k++) req_backlog.push_back(make_timer_req(OpAdd));
    push_add(64'd5, 32'd5, 1'b1, 8'h05, 16'h0005);
    for (int k = 0; k < 7; k++) req_backlog.push_back(make_timer_req(OpPop));
    wait_drained();

    // Random phases across frequency settings and idling patterns
    write_clock_freq(32'd1);
    run_phase(0, 0, 400);
    write_clock_freq('1);
    run_phase(50, 0, 400);
    write_clock_freq(FreqW'($urandom_range(32'hFFFF_FFFE) + 1));
    run_phase(0, 50, 400);
    write_clock_freq(ClockFreqReset);
    run_phase(17, 17, 400);

    // Backpressure: receiver held off while requests keep coming
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    queue_random_items(60);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0) failures++;
    $display("%0d requests accepted, %0d responses checked, %0d frequency writes",
             accepted, checked, freq_writes);
    $display("queue full %0d times, %0d adds dropped, %0d pops on empty queue",
             full_seen, dropped_adds, empty_pops);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/stq_pkg.sv
src/stq_if.sv
src/stq_cell.sv
src/sorted_timer_deadline_queue.sv
tb/tb_sorted_timer_deadline_queue.sv
